FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME_CYCLE(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT_CYCLE(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: rtl/brq_pkg.sv
// shared types and constants of the budgeted relay queue
package brq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TAG_W           = 16;
    localparam int AMT_W           = 32;
    localparam int STAT_W          = 48;
    localparam int LOSS_W          = 17;
    localparam int LOSS_FRAC_W     = 16;
    localparam int QLIM_W          = 7;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int OP_W            = 3;
    localparam int LINK_W          = 2;
    localparam int MAX_PIECES      = 64;
    localparam int PCNT_W          = $clog2(MAX_PIECES + 1);

    localparam logic [AMT_W-1:0]  CAP_RESET  = AMT_W'(1000);
    localparam logic [LOSS_W-1:0] LOSS_RESET = LOSS_W'(3277);
    localparam logic [QLIM_W-1:0] QLIM_RESET = QLIM_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE     = 3'd0,
        OP_TICK        = 3'd1,
        OP_CONNECT     = 3'd2,
        OP_DISCONNECT  = 3'd3,
        OP_SUSPEND     = 3'd4,
        OP_CLEAR       = 3'd5,
        OP_STATS_RESET = 3'd6,
        OP_NOP         = 3'd7
    } op_t;

    typedef enum logic [LINK_W-1:0] {
        LINK_DOWN      = 2'd0,
        LINK_UP        = 2'd1,
        LINK_SUSPENDED = 2'd2
    } link_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY  = 3'd0,
        CFG_LOSS      = 3'd1,
        CFG_QLIMIT    = 3'd2,
        CFG_DROP_DISC = 3'd3
    } cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec_op;
        logic tick_start;
        logic rd;
        logic calc;
        logic mul;
        logic commit;
        logic load_out;
        logic out_piece;
        logic out_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic more;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] amount;
    } entry_t;

endpackage

FILE: rtl/brq_ctrl.sv
// sequencing state machine of the budgeted relay queue
module brq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  brq_pkg::dp_status_t status,
    output brq_pkg::dp_cmd_t    cmd
);
    import brq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_RD,
        ST_CALC,
        ST_MUL,
        ST_COMMIT,
        ST_OUT_PIECE,
        ST_OUT_CTRL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.is_tick) begin
                    cmd.tick_start = 1'b1;
                    state_next     = ST_CHECK;
                end else begin
                    cmd.exec_op = 1'b1;
                    state_next  = ST_OUT_CTRL;
                end
            end
            ST_CHECK: begin
                state_next = status.more ? ST_RD : ST_OUT_CTRL;
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_OUT_PIECE;
            end
            ST_OUT_PIECE: begin
                if (status.out_free) begin
                    cmd.load_out  = 1'b1;
                    cmd.out_piece = 1'b1;
                    cmd.out_last  = !status.more;
                    state_next    = status.more ? ST_RD : ST_IDLE;
                end
            end
            ST_OUT_CTRL: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/brq_datapath.sv
// queue memory, counters, piece arithmetic and result register
module brq_datapath #(
    parameter  int QUEUE_DEPTH = brq_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  brq_pkg::dp_cmd_t                  cmd,
    output brq_pkg::dp_status_t               status,
    input  logic                              cfg_wr_en,
    input  logic [brq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [brq_pkg::OP_W-1:0]          s_op,
    input  logic [brq_pkg::TAG_W-1:0]         s_payload_tag,
    input  logic [brq_pkg::AMT_W-1:0]         s_payload_amount,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic                              m_transfer_valid,
    output logic [brq_pkg::TAG_W-1:0]         m_out_tag,
    output logic [brq_pkg::AMT_W-1:0]         m_out_amount,
    output logic [brq_pkg::AMT_W-1:0]         m_out_lost,
    output logic                              m_last,
    output logic [CNT_W-1:0]                  m_queue_count,
    output logic [brq_pkg::LINK_W-1:0]        m_link_state,
    output logic [brq_pkg::STAT_W-1:0]        m_dropped_total,
    output logic [brq_pkg::STAT_W-1:0]        m_ticks_total,
    output logic [brq_pkg::STAT_W-1:0]        m_transferred_total,
    output logic [brq_pkg::STAT_W-1:0]        m_lost_total
);
    import brq_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LIM_W  = ((CNT_W > QLIM_W) ? CNT_W : QLIM_W) + 1;
    localparam int PROD_W = AMT_W + LOSS_FRAC_W;

    // configuration
    logic [AMT_W-1:0]   cap_reg;
    logic [LOSS_W-1:0]  loss_reg;
    logic [QLIM_W-1:0]  qlim_reg;
    logic               dod_reg;

    // queue control and statistics
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [CNT_W-1:0]   count_reg;
    link_t              link_reg;
    logic [STAT_W-1:0]  drop_reg;
    logic [STAT_W-1:0]  tick_reg;
    logic [STAT_W-1:0]  moved_reg;
    logic [STAT_W-1:0]  lostsum_reg;
    logic [PCNT_W-1:0]  npieces_reg;
    logic               m_valid_reg;

    // captured word and walk registers
    op_t                op_reg;
    logic [TAG_W-1:0]   tag_in_reg;
    logic [AMT_W-1:0]   amt_in_reg;
    logic               acc_reg;
    logic [AMT_W-1:0]   budget_reg;
    entry_t             rd_entry_reg;
    logic [TAG_W-1:0]   ptag_reg;
    logic [AMT_W-1:0]   piece_reg;
    logic [AMT_W-1:0]   rem_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TAG_W-1:0]   res_tag_reg;
    logic [AMT_W-1:0]   res_got_reg;
    logic [AMT_W-1:0]   res_lost_reg;

    // result register
    logic               m_accepted_reg;
    logic               m_transfer_valid_reg;
    logic [TAG_W-1:0]   m_out_tag_reg;
    logic [AMT_W-1:0]   m_out_amount_reg;
    logic [AMT_W-1:0]   m_out_lost_reg;
    logic               m_last_reg;
    logic [CNT_W-1:0]   m_queue_count_reg;
    logic [LINK_W-1:0]  m_link_state_reg;
    logic [STAT_W-1:0]  m_dropped_total_reg;
    logic [STAT_W-1:0]  m_ticks_total_reg;
    logic [STAT_W-1:0]  m_transferred_total_reg;
    logic [STAT_W-1:0]  m_lost_total_reg;

    entry_t mem [QUEUE_DEPTH];

    logic [LIM_W-1:0]   qlim_ext;
    logic [LIM_W-1:0]   depth_ext;
    logic [LIM_W-1:0]   eff_limit;
    logic               q_full;
    logic               link_up;
    logic               enq_ok;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [AMT_W-1:0]   have;
    logic [AMT_W-1:0]   piece_c;
    logic [AMT_W-1:0]   lost_c;
    logic [AMT_W-1:0]   got_c;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // a limit of zero or above the depth means the whole depth
    assign qlim_ext  = LIM_W'(qlim_reg);
    assign depth_ext = LIM_W'(QUEUE_DEPTH);
    assign eff_limit = (qlim_reg == '0 || qlim_ext > depth_ext) ? depth_ext : qlim_ext;
    assign q_full    = LIM_W'(count_reg) >= eff_limit;
    assign link_up   = (link_reg == LINK_UP);
    assign enq_ok    = cmd.exec_op && (op_reg == OP_ENQUEUE) && link_up && !q_full;

    assign have    = rd_entry_reg.amount;
    assign piece_c = (have < budget_reg) ? have : budget_reg;
    assign lost_c  = loss_reg[LOSS_W-1] ? piece_reg : prod_reg[PROD_W-1:LOSS_FRAC_W];
    assign got_c   = piece_reg - lost_c;

    assign mem_we    = enq_ok || cmd.commit;
    assign mem_waddr = cmd.commit ? head_reg : tail_reg;
    assign mem_wdata = cmd.commit ? '{tag: ptag_reg, amount: rem_reg}
                                  : '{tag: tag_in_reg, amount: amt_in_reg};

    assign status.is_tick  = (op_reg == OP_TICK);
    assign status.more     = link_up && (count_reg != '0) && (budget_reg != '0)
                             && (npieces_reg < PCNT_W'(MAX_PIECES));
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd) begin
            rd_entry_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            loss_reg    <= LOSS_RESET;
            qlim_reg    <= QLIM_RESET;
            dod_reg     <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            link_reg    <= LINK_DOWN;
            drop_reg    <= '0;
            tick_reg    <= '0;
            moved_reg   <= '0;
            lostsum_reg <= '0;
            npieces_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_CAPACITY:  cap_reg  <= cfg_wdata[AMT_W-1:0];
                    CFG_LOSS:      loss_reg <= cfg_wdata[LOSS_W-1:0];
                    CFG_QLIMIT:    qlim_reg <= cfg_wdata[QLIM_W-1:0];
                    CFG_DROP_DISC: dod_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.exec_op) begin
                unique case (op_reg)
                    OP_ENQUEUE: begin
                        if (link_up) begin
                            if (q_full) begin
                                drop_reg <= drop_reg + STAT_W'(1);
                            end else begin
                                tail_reg  <= ptr_inc(tail_reg);
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_CONNECT: begin
                        link_reg <= LINK_UP;
                    end
                    OP_DISCONNECT: begin
                        link_reg <= LINK_DOWN;
                        if (dod_reg) begin
                            drop_reg  <= drop_reg + STAT_W'(count_reg);
                            count_reg <= '0;
                            tail_reg  <= head_reg;
                        end
                    end
                    OP_SUSPEND: begin
                        link_reg <= LINK_SUSPENDED;
                    end
                    OP_CLEAR: begin
                        count_reg <= '0;
                        tail_reg  <= head_reg;
                    end
                    OP_STATS_RESET: begin
                        drop_reg    <= '0;
                        tick_reg    <= '0;
                        moved_reg   <= '0;
                        lostsum_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.tick_start) begin
                tick_reg    <= tick_reg + STAT_W'(1);
                npieces_reg <= '0;
            end
            if (cmd.commit) begin
                moved_reg   <= moved_reg + STAT_W'(got_c);
                lostsum_reg <= lostsum_reg + STAT_W'(lost_c);
                npieces_reg <= npieces_reg + PCNT_W'(1);
                // fully taken head leaves the queue
                if (rem_reg == '0) begin
                    head_reg  <= ptr_inc(head_reg);
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= op_t'(s_op);
            tag_in_reg <= s_payload_tag;
            amt_in_reg <= s_payload_amount;
            acc_reg    <= 1'b0;
        end else if (enq_ok) begin
            acc_reg <= 1'b1;
        end
        if (cmd.tick_start) begin
            budget_reg <= cap_reg;
        end else if (cmd.commit) begin
            budget_reg <= budget_reg - piece_reg;
        end
        if (cmd.calc) begin
            ptag_reg  <= rd_entry_reg.tag;
            piece_reg <= piece_c;
            rem_reg   <= have - piece_c;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(piece_reg) * PROD_W'(loss_reg[LOSS_FRAC_W-1:0]);
        end
        if (cmd.commit) begin
            res_tag_reg  <= ptag_reg;
            res_got_reg  <= got_c;
            res_lost_reg <= lost_c;
        end
        if (cmd.load_out) begin
            m_accepted_reg          <= cmd.out_piece ? 1'b0 : acc_reg;
            m_transfer_valid_reg    <= cmd.out_piece;
            m_out_tag_reg           <= cmd.out_piece ? res_tag_reg : '0;
            m_out_amount_reg        <= cmd.out_piece ? res_got_reg : '0;
            m_out_lost_reg          <= cmd.out_piece ? res_lost_reg : '0;
            m_last_reg              <= cmd.out_last;
            m_queue_count_reg       <= count_reg;
            m_link_state_reg        <= link_reg;
            m_dropped_total_reg     <= drop_reg;
            m_ticks_total_reg       <= tick_reg;
            m_transferred_total_reg <= moved_reg;
            m_lost_total_reg        <= lostsum_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_accepted          = m_accepted_reg;
    assign m_transfer_valid    = m_transfer_valid_reg;
    assign m_out_tag           = m_out_tag_reg;
    assign m_out_amount        = m_out_amount_reg;
    assign m_out_lost          = m_out_lost_reg;
    assign m_last              = m_last_reg;
    assign m_queue_count       = m_queue_count_reg;
    assign m_link_state        = m_link_state_reg;
    assign m_dropped_total     = m_dropped_total_reg;
    assign m_ticks_total       = m_ticks_total_reg;
    assign m_transferred_total = m_transferred_total_reg;
    assign m_lost_total        = m_lost_total_reg;

endmodule

FILE: rtl/budgeted_relay_queue.sv
// top level of the budgeted relay queue: controller, datapath and checks
// A bounded queue of payloads (tag and amount) drained by tick words under a per-tick amount
// budget, splitting the head payload when the budget runs out and reporting every piece with
// its delivered and lost parts. One input word is handled at a time. A control or enqueue word
// is accepted, executed and loaded into the result register. A tick is accepted, executed and
// checked and loads the result register if it moves nothing; otherwise each piece goes through
// a registered read of the queue memory, a budget compare, the 32x16 loss multiply, the
// write-back and counter update, and the result register, loaded only once its word is free;
// the single memory read port and the multiply set this order. A finished result may wait in
// the result register while the next word is accepted. After reset the queue is empty and
// ready at once: the queue memory holds no reset value and is never read at an unwritten slot.
`include "assert_macros.svh"

module budgeted_relay_queue #(
    parameter  int QUEUE_DEPTH = brq_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [brq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [brq_pkg::OP_W-1:0]          s_op,
    input  logic [brq_pkg::TAG_W-1:0]         s_payload_tag,
    input  logic [brq_pkg::AMT_W-1:0]         s_payload_amount,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic                              m_transfer_valid,
    output logic [brq_pkg::TAG_W-1:0]         m_out_tag,
    output logic [brq_pkg::AMT_W-1:0]         m_out_amount,
    output logic [brq_pkg::AMT_W-1:0]         m_out_lost,
    output logic                              m_last,
    output logic [CNT_W-1:0]                  m_queue_count,
    output logic [brq_pkg::LINK_W-1:0]        m_link_state,
    output logic [brq_pkg::STAT_W-1:0]        m_dropped_total,
    output logic [brq_pkg::STAT_W-1:0]        m_ticks_total,
    output logic [brq_pkg::STAT_W-1:0]        m_transferred_total,
    output logic [brq_pkg::STAT_W-1:0]        m_lost_total
);
    import brq_pkg::*;

    // command and status buses between the two halves
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: walks one word through execute, and a tick through its pieces
    brq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // queue storage, statistics, loss arithmetic and the result register
    brq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_op                (s_op),
        .s_payload_tag       (s_payload_tag),
        .s_payload_amount    (s_payload_amount),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_transfer_valid    (m_transfer_valid),
        .m_out_tag           (m_out_tag),
        .m_out_amount        (m_out_amount),
        .m_out_lost          (m_out_lost),
        .m_last              (m_last),
        .m_queue_count       (m_queue_count),
        .m_link_state        (m_link_state),
        .m_dropped_total     (m_dropped_total),
        .m_ticks_total       (m_ticks_total),
        .m_transferred_total (m_transferred_total),
        .m_lost_total        (m_lost_total)
    );

    // an accepted word keeps the intake closed while it is worked on
    `ASSERT_NEXT_CYCLE(a_intake_closes, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a transferred piece is never reported as an accepted enqueue
    `ASSERT_SAME_CYCLE(a_piece_not_acc, aclk, aresetn, m_valid && m_transfer_valid, !m_accepted)
    // pieces only move while the link is connected
    `ASSERT_SAME_CYCLE(a_piece_link_up, aclk, aresetn, m_valid && m_transfer_valid, m_link_state == LINK_UP)
    // the result register is only reloaded once its word is free
    `ASSERT_SAME_CYCLE(a_load_when_free, aclk, aresetn, cmd.load_out, !m_valid || m_ready)

endmodule

FILE: sim/budgeted_relay_queue_tb.sv
// self-checking testbench for the budgeted relay queue
`timescale 1ns / 100ps

module budgeted_relay_queue_tb;
    import brq_pkg::*;

    localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
    localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no word accepted on either side
    localparam int END_SETTLE     = 16;     // cycles watched for stray words at the end
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_WORDS    = 50;
    localparam logic [LOSS_W-1:0] LOSS_ALL = LOSS_W'(65536);

    // one result word as the block presents it
    typedef struct packed {
        logic                 accepted;
        logic                 moved;
        logic [TAG_W-1:0]     tag;
        logic [AMT_W-1:0]     delivered;
        logic [AMT_W-1:0]     lost;
        logic                 last;
        logic [COUNT_W-1:0]   count;
        link_t                link;
        logic [STAT_W-1:0]    drops;
        logic [STAT_W-1:0]    ticks;
        logic [STAT_W-1:0]    moved_sum;
        logic [STAT_W-1:0]    lost_sum;
    } relay_word_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [OP_W-1:0]        s_op;
    logic [TAG_W-1:0]       s_payload_tag;
    logic [AMT_W-1:0]       s_payload_amount;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_accepted;
    logic                   m_transfer_valid;
    logic [TAG_W-1:0]       m_out_tag;
    logic [AMT_W-1:0]       m_out_amount;
    logic [AMT_W-1:0]       m_out_lost;
    logic                   m_last;
    logic [COUNT_W-1:0]     m_queue_count;
    logic [LINK_W-1:0]      m_link_state;
    logic [STAT_W-1:0]      m_dropped_total;
    logic [STAT_W-1:0]      m_ticks_total;
    logic [STAT_W-1:0]      m_transferred_total;
    logic [STAT_W-1:0]      m_lost_total;

    budgeted_relay_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_payload_tag       (s_payload_tag),
        .s_payload_amount    (s_payload_amount),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_transfer_valid    (m_transfer_valid),
        .m_out_tag           (m_out_tag),
        .m_out_amount        (m_out_amount),
        .m_out_lost          (m_out_lost),
        .m_last              (m_last),
        .m_queue_count       (m_queue_count),
        .m_link_state        (m_link_state),
        .m_dropped_total     (m_dropped_total),
        .m_ticks_total       (m_ticks_total),
        .m_transferred_total (m_transferred_total),
        .m_lost_total        (m_lost_total)
    );

    // ------------------------------------------------------------------
    // shadow copy of the queue, link and statistics, plus register values
    // ------------------------------------------------------------------
    logic [TAG_W-1:0]   shadow_tag [QUEUE_DEPTH];
    logic [AMT_W-1:0]   shadow_amt [QUEUE_DEPTH];
    int                 shadow_head;
    int                 shadow_count;
    link_t              shadow_link;
    logic [STAT_W-1:0]  drop_sum;
    logic [STAT_W-1:0]  tick_sum;
    logic [STAT_W-1:0]  moved_sum;
    logic [STAT_W-1:0]  lost_sum;

    logic [AMT_W-1:0]   cap_reg;
    logic [LOSS_W-1:0]  loss_reg;
    logic [QLIM_W-1:0]  qlimit_reg;
    logic               drop_disc_reg;

    relay_word_t        expected_words[$];  // words still owed by the block, oldest first
    int                 fault_count;
    int                 shown_faults;
    bit                 steady_feed;        // 1 while the sender never pauses

    // clock, 4 ns period
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void reset_relay_model();
        shadow_head   = 0;
        shadow_count  = 0;
        shadow_link   = LINK_DOWN;
        drop_sum      = '0;
        tick_sum      = '0;
        moved_sum     = '0;
        lost_sum      = '0;
        cap_reg       = CAP_RESET;
        loss_reg      = LOSS_RESET;
        qlimit_reg    = QLIM_RESET;
        drop_disc_reg = 1'b0;
    endfunction

    // queue one expected word, built from the shadow state as it now stands
    function automatic void owe_word(logic acc, logic moved, logic [TAG_W-1:0] tag,
                                     logic [AMT_W-1:0] delivered, logic [AMT_W-1:0] lost);
        relay_word_t w;
        w.accepted  = acc;
        w.moved     = moved;
        w.tag       = tag;
        w.delivered = delivered;
        w.lost      = lost;
        w.last      = 1'b0;
        w.count     = COUNT_W'(shadow_count);
        w.link      = shadow_link;
        w.drops     = drop_sum;
        w.ticks     = tick_sum;
        w.moved_sum = moved_sum;
        w.lost_sum  = lost_sum;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // works out every word that one accepted input word causes
    function automatic void relay_predict(op_t op, logic [TAG_W-1:0] tag,
                                          logic [AMT_W-1:0] amt);
        logic [AMT_W-1:0] budget;
        logic [AMT_W-1:0] have;
        logic [AMT_W-1:0] piece;
        logic [AMT_W-1:0] lost;
        logic [63:0]      prod;
        logic [TAG_W-1:0] piece_tag;
        int               limit;
        int               pieces;
        int               slot;
        logic             acc;

        pieces = 0;
        acc    = 1'b0;
        limit  = (qlimit_reg == 0 || qlimit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(qlimit_reg);
        case (op)
            OP_ENQUEUE: begin
                if (shadow_link == LINK_UP) begin
                    if (shadow_count >= limit) begin
                        drop_sum = drop_sum + 1'b1;
                    end else begin
                        slot = (shadow_head + shadow_count) % QUEUE_DEPTH;
                        shadow_tag[slot] = tag;
                        shadow_amt[slot] = amt;
                        shadow_count++;
                        acc = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                budget   = cap_reg;
                tick_sum = tick_sum + 1'b1;
                if (shadow_link == LINK_UP) begin
                    while (shadow_count > 0 && budget != 0 && pieces < MAX_PIECES) begin
                        have  = shadow_amt[shadow_head];
                        piece = (have < budget) ? have : budget;
                        if (loss_reg == 0) begin
                            lost = '0;
                        end else if (loss_reg >= LOSS_ALL) begin
                            lost = piece;
                        end else begin
                            prod = 64'(piece) * 64'(loss_reg);
                            lost = AMT_W'(prod >> LOSS_FRAC_W);
                        end
                        moved_sum = moved_sum + STAT_W'(piece - lost);
                        lost_sum  = lost_sum + STAT_W'(lost);
                        shadow_amt[shadow_head] = have - piece;
                        budget    = budget - piece;
                        piece_tag = shadow_tag[shadow_head];
                        // fully taken, zero-amount items included, leave the head
                        if (shadow_amt[shadow_head] == 0) begin
                            shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
                            shadow_count--;
                        end
                        owe_word(1'b0, 1'b1, piece_tag, piece - lost, lost);
                        pieces++;
                    end
                end
            end
            OP_CONNECT:  shadow_link = LINK_UP;
            OP_DISCONNECT: begin
                shadow_link = LINK_DOWN;
                if (drop_disc_reg) begin
                    drop_sum     = drop_sum + STAT_W'(shadow_count);
                    shadow_count = 0;
                end
            end
            OP_SUSPEND:  shadow_link = LINK_SUSPENDED;
            OP_CLEAR:    shadow_count = 0;
            OP_STATS_RESET: begin
                drop_sum  = '0;
                tick_sum  = '0;
                moved_sum = '0;
                lost_sum  = '0;
            end
            default: ;
        endcase
        if (pieces == 0)
            owe_word(acc, 1'b0, '0, '0, '0);
        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [AMT_W-1:0] rand_amount();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            7, 8:    return AMT_W'($urandom_range(0, 65535));
            9:       return AMT_W'($urandom);
            default: return AMT_W'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic string fmt_word(relay_word_t w);
        return $sformatf({"acc=%0d xfer=%0d tag=%h amt=%0d lost=%0d last=%0d cnt=%0d ",
                          "link=%0d drop=%0d tick=%0d moved=%0d lostsum=%0d"},
                         w.accepted, w.moved, w.tag, w.delivered, w.lost, w.last, w.count,
                         w.link, w.drops, w.ticks, w.moved_sum, w.lost_sum);
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // presents one input word, holds it until the handshake, then predicts
    task automatic send_word(op_t op, logic [TAG_W-1:0] tag, logic [AMT_W-1:0] amt);
        int gap;
        gap = steady_feed ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_payload_tag    <= tag;
        s_payload_amount <= amt;
        do @(posedge aclk); while (!s_ready);
        relay_predict(op, tag, amt);
    endtask

    // stop sending and wait until every owed word has come back
    task automatic settle_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (cfg_idx_t'(idx))
            CFG_CAPACITY:  cap_reg       = AMT_W'(data);
            CFG_LOSS:      loss_reg      = LOSS_W'(data);
            CFG_QLIMIT:    qlimit_reg    = QLIM_W'(data);
            CFG_DROP_DISC: drop_disc_reg = data[0];
            default: ;     // unmapped index, no effect
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: refusals while down, split head, suspend, every control op
    task automatic test_link_and_split();
        send_word(OP_ENQUEUE, 16'h1234, 32'd50);         // refused, link down
        send_word(OP_TICK, 16'h0000, 32'd0);             // counted, nothing moves
        send_word(OP_CONNECT, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_ENQUEUE, 16'h0000, 32'd0);
        send_word(OP_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_ENQUEUE, 16'h00A5, 32'd1500);
        send_word(OP_TICK, 16'h5A5A, 32'd0);             // zero item popped, big one split
        send_word(OP_TICK, 16'h0000, 32'd7);
        send_word(OP_SUSPEND, 16'h0001, 32'd1);
        send_word(OP_ENQUEUE, 16'h7777, 32'd10);         // refused while suspended
        send_word(OP_TICK, 16'h0000, 32'd0);             // suspended, nothing moves
        send_word(OP_CONNECT, 16'h0000, 32'd0);
        send_word(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_STATS_RESET, 16'h0000, 32'd0);
        send_word(OP_DISCONNECT, 16'h0000, 32'd0);       // queue kept, drop flag off
        send_word(OP_CONNECT, 16'h0000, 32'd0);
        send_word(OP_CLEAR, 16'h0000, 32'd0);
        send_word(OP_TICK, 16'h0000, 32'd0);             // empty queue
    endtask

    // zero and full budget, loss extremes, full queue, drop on disconnect
    task automatic test_register_extremes();
        settle_idle();
        for (int i = int'(CFG_DROP_DISC) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        write_reg(CFG_CAPACITY, '0);
        write_reg(CFG_LOSS, '0);
        write_reg(CFG_QLIMIT, 32'hFFFF_FF01);            // upper bits ignored, limit 1
        write_reg(CFG_DROP_DISC, 32'hFFFF_FFFF);
        send_word(OP_ENQUEUE, 16'h0001, 32'd0);
        send_word(OP_ENQUEUE, 16'h0002, 32'd5);          // queue full, counted as drop
        send_word(OP_TICK, 16'h0000, 32'd0);             // zero budget keeps zero item
        send_word(OP_DISCONNECT, 16'h0000, 32'd0);       // drops the queued item

        settle_idle();
        write_reg(CFG_CAPACITY, '1);
        write_reg(CFG_LOSS, 32'hABCD_0000);              // exactly one: everything lost
        write_reg(CFG_QLIMIT, 32'd127);                  // above depth means full depth
        write_reg(CFG_DROP_DISC, 32'hFFFF_FFFE);
        send_word(OP_CONNECT, 16'h0000, 32'd0);
        send_word(OP_ENQUEUE, 16'h0003, 32'hFFFF_FFFF);
        send_word(OP_ENQUEUE, 16'h0004, 32'd7);
        send_word(OP_TICK, 16'h0000, 32'd0);             // max budget spent on one piece
        send_word(OP_TICK, 16'h0000, 32'd0);

        settle_idle();
        write_reg(CFG_LOSS, 32'hFFFF_FFFF);              // above one, still all lost
        write_reg(CFG_CAPACITY, 32'd10);
        send_word(OP_ENQUEUE, 16'h0005, 32'd10);
        send_word(OP_ENQUEUE, 16'h0006, 32'd0);
        send_word(OP_TICK, 16'h0000, 32'd0);             // budget used up, zero item waits
        send_word(OP_TICK, 16'h0000, 32'd0);

        settle_idle();
        write_reg(CFG_LOSS, 32'd65535);
        write_reg(CFG_CAPACITY, 32'd1);
        send_word(OP_ENQUEUE, 16'h0007, 32'd2);
        send_word(OP_TICK, 16'h0000, 32'd0);
        send_word(OP_TICK, 16'h0000, 32'd0);
    endtask

    // fill all slots, overflow once, then drain them all in one tick
    task automatic test_full_depth_drain();
        settle_idle();
        write_reg(CFG_QLIMIT, '0);
        write_reg(CFG_CAPACITY, '1);
        write_reg(CFG_LOSS, CFG_DATA_W'($urandom_range(0, 65535)));
        steady_feed = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_word(OP_ENQUEUE, TAG_W'($urandom), AMT_W'($urandom_range(0, 300)));
        steady_feed = 1'b0;
        send_word(OP_ENQUEUE, TAG_W'($urandom), rand_amount());
        send_word(OP_TICK, 16'h0000, 32'd0);             // the most words one tick gives
        send_word(OP_TICK, 16'h0000, 32'd0);
    endtask

    // random phases, each under fresh settings; mostly connected traffic
    task automatic test_random_traffic();
        int   r;
        op_t  op;
        for (int phase = 0; phase < 4; phase++) begin
            settle_idle();
            r = $urandom_range(0, 19);
            write_reg(CFG_CAPACITY, (r == 0) ? '0 : (r == 1) ? '1 :
                                    (r < 12) ? CFG_DATA_W'($urandom_range(1, 1500)) :
                                    (r < 18) ? CFG_DATA_W'($urandom_range(1500, 20000)) :
                                    CFG_DATA_W'($urandom));
            r = $urandom_range(0, 9);
            write_reg(CFG_LOSS, ($urandom & ~32'h1FFFF) |
                                ((r == 0) ? 32'd0 : (r == 1) ? 32'd65536 :
                                 (r == 2) ? 32'h1FFFF : 32'($urandom_range(0, 65535))));
            write_reg(CFG_QLIMIT, ($urandom_range(0, 1) == 0) ?
                                  CFG_DATA_W'($urandom_range(1, 8)) : CFG_DATA_W'($urandom));
            write_reg(CFG_DROP_DISC, CFG_DATA_W'($urandom));
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_DROP_DISC) + 1, 7)),
                      CFG_DATA_W'($urandom));
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i % 25 == 0)
                    steady_feed = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (shadow_link != LINK_UP && r < 60) op = OP_CONNECT;
                else begin
                    r = $urandom_range(0, 99);
                    if      (r < 50) op = OP_ENQUEUE;
                    else if (r < 80) op = OP_TICK;
                    else if (r < 84) op = OP_CONNECT;
                    else if (r < 88) op = OP_DISCONNECT;
                    else if (r < 91) op = OP_SUSPEND;
                    else if (r < 94) op = OP_CLEAR;
                    else if (r < 96) op = OP_STATS_RESET;
                    else             op = OP_NOP;
                end
                send_word(op, TAG_W'($urandom), rand_amount());
            end
        end
        steady_feed = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    initial begin
        int hold;
        int run;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            hold = pick_gap();
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            // now and then a long stretch without any stall
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            repeat (run - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        relay_word_t got;
        relay_word_t want;
        string       diff;
        if (aresetn && m_valid && m_ready) begin
            got.accepted  = m_accepted;
            got.moved     = m_transfer_valid;
            got.tag       = m_out_tag;
            got.delivered = m_out_amount;
            got.lost      = m_out_lost;
            got.last      = m_last;
            got.count     = m_queue_count;
            got.link      = link_t'(m_link_state);
            got.drops     = m_dropped_total;
            got.ticks     = m_ticks_total;
            got.moved_sum = m_transferred_total;
            got.lost_sum  = m_lost_total;
            if (expected_words.size() == 0) begin
                fault_count++;
                if (shown_faults < REPORT_LIMIT) begin
                    shown_faults++;
                    $display("unexpected word: %s", fmt_word(got));
                end
            end else begin
                want = expected_words[0];
                expected_words.delete(0);
                diff = "";
                if (got.accepted  !== want.accepted)  diff = {diff, " accepted"};
                if (got.moved     !== want.moved)     diff = {diff, " transfer_valid"};
                if (got.tag       !== want.tag)       diff = {diff, " out_tag"};
                if (got.delivered !== want.delivered) diff = {diff, " out_amount"};
                if (got.lost      !== want.lost)      diff = {diff, " out_lost"};
                if (got.last      !== want.last)      diff = {diff, " last"};
                if (got.count     !== want.count)     diff = {diff, " queue_count"};
                if (got.link      !== want.link)      diff = {diff, " link_state"};
                if (got.drops     !== want.drops)     diff = {diff, " dropped_total"};
                if (got.ticks     !== want.ticks)     diff = {diff, " ticks_total"};
                if (got.moved_sum !== want.moved_sum) diff = {diff, " transferred_total"};
                if (got.lost_sum  !== want.lost_sum)  diff = {diff, " lost_total"};
                if (diff != "") begin
                    fault_count++;
                    if (shown_faults < REPORT_LIMIT) begin
                        shown_faults++;
                        $display("mismatch at %0t in%s", $realtime, diff);
                        $display("  expected %s", fmt_word(want));
                        $display("  actual   %s", fmt_word(got));
                    end
                end
            end
        end
    end

    // watchdog: ends the run once nothing has moved on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------
    initial begin
        s_valid          = 1'b0;
        s_op             = OP_NOP;
        s_payload_tag    = '0;
        s_payload_amount = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        aresetn          = 1'b0;
        steady_feed      = 1'b0;
        fault_count      = 0;
        shown_faults     = 0;
        reset_relay_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_link_and_split();
        test_register_extremes();
        test_full_depth_drain();
        test_random_traffic();

        // everything owed has to arrive, then watch for strays
        settle_idle();
        repeat (END_SETTLE) @(posedge aclk);
        if (fault_count == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/brq_pkg.sv
rtl/brq_ctrl.sv
rtl/brq_datapath.sv
rtl/budgeted_relay_queue.sv
sim/budgeted_relay_queue_tb.sv
